[rtl/sil_pkg.sv]
package sil_pkg;

   // List geometry
   localparam int DEPTH    = 64;
   localparam int VALUE_W  = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W    = 6;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Read select tree: groups of eight entries
   localparam int GRP_SIZE  = 8;
   localparam int GRP_LO_W  = $clog2(GRP_SIZE);
   localparam int NUM_GRPS  = DEPTH / GRP_SIZE;
   localparam int GRP_IDX_W = IDX_W - GRP_LO_W;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic      ins_en;
      logic      ers_en;
      value_type value;
      count_type count;
      idx_type   pos;
   } cell_cmd_type;

endpackage

[rtl/sil_cell.sv]
module sil_cell (
   input  logic                  clock,
   input  sil_pkg::cell_cmd_type cmd,
   input  sil_pkg::idx_type      cell_idx,
   input  sil_pkg::value_type    left_entry,
   input  logic                  left_mark,
   input  sil_pkg::value_type    right_entry,
   output sil_pkg::value_type    entry,
   output logic                  mark
);
   import sil_pkg::*;

   value_type entry_ff;
   value_type entry_in;

   // Mark: slot is empty or holds an entry not smaller than the new value
   assign mark = (COUNT_W'(cell_idx) >= cmd.count) || (entry_ff >= cmd.value);

   // Insert shifts up from the left, erase shifts down from the right
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en && mark) begin
         entry_in = left_mark ? left_entry : cmd.value;
      end else if (cmd.ers_en && (cell_idx >= cmd.pos)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/sil_rdsel.sv]
module sil_rdsel (
   input  logic               clock,
   input  logic               load,
   input  sil_pkg::idx_type   pos,
   input  sil_pkg::value_type entries [sil_pkg::DEPTH],
   output sil_pkg::value_type rd_data
);
   import sil_pkg::*;

   value_type grp_ff [NUM_GRPS];
   logic [GRP_LO_W-1:0]  pos_lo;
   logic [GRP_IDX_W-1:0] pos_hi;

   assign pos_lo = pos[GRP_LO_W-1:0];
   assign pos_hi = pos[IDX_W-1:GRP_LO_W];

   // First level: pick the same offset in every group
   for (genvar g = 0; g < NUM_GRPS; g++) begin : g_grp
      always_ff @(posedge clock) begin
         if (load) begin
            grp_ff[g] <= entries[{GRP_IDX_W'(g), pos_lo}];
         end
      end
   end

   // Second level: pick the group
   assign rd_data = grp_ff[pos_hi];

endmodule

[rtl/sorted_insertion_list_top.sv]
// Sorted insertion list: ascending unsigned entries held in a row of cells.
// Requests are taken only in the idle state: a new item is not accepted until the
// previous one has passed the registered first level of the read select and
// been loaded into the response register, which can stall on back-pressure.
// Reset clears the entry count and the response valid, and sets capacity to 64;
// entry contents are not cleared.
module sorted_insertion_list_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sil_pkg::COUNT_W-1:0]  csr_capacity,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [sil_pkg::ACTION_W-1:0] req_action,
   input  logic [sil_pkg::VALUE_W-1:0]  req_value,
   input  logic [sil_pkg::POS_W-1:0]    req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sil_pkg::VALUE_W-1:0]  rsp_data,
   output logic [sil_pkg::STATUS_W-1:0] rsp_status,
   output logic [sil_pkg::COUNT_W-1:0]  rsp_count
);
   import sil_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SEL, S_OUT} state_type;

   state_type            state_ff;
   count_type            count_ff, count_in;
   count_type            cap_ff;
   count_type            eff_cap;
   idx_type              pos_ff;
   logic                 rd_ok_ff, rd_ok_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   count_type            res_count_ff;
   logic                 rsp_valid_ff;
   value_type            rsp_data_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   count_type            rsp_count_ff;

   logic                 req_xfer;
   logic                 out_load;
   logic                 full;
   logic                 pos_ok;
   idx_type              req_pos;
   cell_cmd_type         cmd;
   value_type            entries [DEPTH];
   logic                 marks   [DEPTH];
   value_type            rd_data;

   assign req_pos   = req_position[IDX_W-1:0];
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Capacity saturates at the depth
   assign eff_cap = (cap_ff > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : cap_ff;
   assign full    = (count_ff >= eff_cap);
   assign pos_ok  = (COUNT_W'(req_pos) < count_ff);

   // Command to the cell row, valid only in the transfer cycle
   always_comb begin
      cmd.ins_en = req_xfer && (req_action == ACT_INSERT) && !full;
      cmd.ers_en = req_xfer && (req_action == ACT_ERASE) && pos_ok;
      cmd.value  = req_value;
      cmd.count  = count_ff;
      cmd.pos    = req_pos;
   end

   // Next count and result status
   always_comb begin
      count_in      = count_ff;
      res_status_in = ST_DONE;
      rd_ok_in      = 1'b0;
      unique case (req_action)
         ACT_INSERT: begin
            if (full) begin
               res_status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_ERASE: begin
            if (!pos_ok) begin
               res_status_in = ST_RANGE;
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         ACT_READ: begin
            if (!pos_ok) begin
               res_status_in = ST_RANGE;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            res_status_in = ST_DONE;
         end
      endcase
   end

   // Row of cells, each neighbor-linked
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_entry;
      logic      left_mark;
      value_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_mark  = 1'b0;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_mark  = marks[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      sil_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (IDX_W'(i)),
         .left_entry  (left_entry),
         .left_mark   (left_mark),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .mark        (marks[i])
      );
   end

   // Read select over the stable cell row
   sil_rdsel u_rdsel (
      .clock   (clock),
      .load    (state_ff == S_SEL),
      .pos     (pos_ff),
      .entries (entries),
      .rd_data (rd_data)
   );

   // Control, capacity and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= COUNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
         if (rsp_valid_ff && rsp_ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  count_ff      <= count_in;
                  pos_ff        <= req_pos;
                  rd_ok_ff      <= rd_ok_in && (req_action == ACT_READ);
                  res_status_ff <= res_status_in;
                  res_count_ff  <= count_in;
                  state_ff      <= S_SEL;
               end
            end
            S_SEL: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= rd_ok_ff ? rd_data : '0;
                  rsp_status_ff <= res_status_ff;
                  rsp_count_ff  <= res_count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // Count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count above depth");

   // Successful insert grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("insert did not grow count");

   // Successful erase shrinks the list by one
   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.ers_en |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("erase did not shrink count");

   // Leaving the output state always presents a response
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("response not presented");

endmodule

[tb/tb_sorted_insertion_list_top.sv]
`timescale 1ns / 100ps

module tb_sorted_insertion_list_top;
   import sil_pkg::*;

   // The action field's fourth code does nothing
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD = 80;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      value_type           value;
      logic [POS_W-1:0]    position;
   } list_req_type;

   typedef struct packed {
      value_type           data;
      logic [STATUS_W-1:0] status;
      count_type           count;
   } list_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_capacity = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   // Predicted list contents and settings
   value_type sorted_vals [DEPTH];
   int        list_len = 0;
   int        cap_limit = DEPTH;

   list_req_type pending_reqs[$];
   list_rsp_type expected_rsps[$];
   list_req_type next_req;
   list_rsp_type exp_rsp;

   logic req_taken = 1'b0;
   logic no_idle = 1'b0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   hold_left = 0;
   int   hold_grant = 0;
   int   hold_seen = 0;
   int   queued_count = 0;
   int   accepted_count = 0;
   int   mismatch_count = 0;
   int   cap_writes = 0;
   int   peak_len = 0;
   int   n_act [4] = '{0, 0, 0, 0};
   int   n_full = 0;
   int   n_range = 0;

   sorted_insertion_list_top uut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Apply one action to the predicted list and return the response it gives
   function automatic list_rsp_type apply_action(input list_req_type rq);
      list_rsp_type rs;
      int        slot;
      int        eff_cap;
      rs.data = '0;
      rs.status = ST_DONE;
      eff_cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
      case (rq.action)
         ACT_INSERT: begin
            if (list_len >= eff_cap) begin
               rs.status = ST_FULL;
            end else begin
               // lands before any equal entries
               slot = 0;
               while (slot < list_len && sorted_vals[slot] < rq.value) slot++;
               for (int i = list_len; i > slot; i--) sorted_vals[i] = sorted_vals[i-1];
               sorted_vals[slot] = rq.value;
               list_len++;
            end
         end
         ACT_ERASE: begin
            if (rq.position >= list_len) begin
               rs.status = ST_RANGE;
            end else begin
               for (int i = rq.position; i + 1 < list_len; i++)
                  sorted_vals[i] = sorted_vals[i+1];
               list_len--;
            end
         end
         ACT_READ: begin
            if (rq.position >= list_len) rs.status = ST_RANGE;
            else rs.data = sorted_vals[rq.position];
         end
         default: ;
      endcase
      rs.count = count_type'(list_len);
      return rs;
   endfunction

   // Request driver: new payload only after the previous transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_action <= next_req.action;
            req_value <= next_req.value;
            req_position <= next_req.position;
            if (!no_idle && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response acceptor: random bursts of back-pressure plus one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_grant) begin
         hold_seen <= hold_grant;
         hold_left <= LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: check response transfers, predict on request transfers
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response data %h status %0d count %0d",
                                         rsp_data, rsp_status, rsp_count));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data !== exp_rsp.data)
                  report_mismatch($sformatf("data %h, expected %h", rsp_data, exp_rsp.data));
               if (rsp_status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, exp_rsp.status));
               if (rsp_count !== exp_rsp.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_count, exp_rsp.count));
            end
         end
         if (req_valid && req_ready) begin
            exp_rsp = apply_action('{req_action, req_value, req_position});
            expected_rsps.push_back(exp_rsp);
            accepted_count++;
            n_act[req_action]++;
            if (exp_rsp.status == ST_FULL) n_full++;
            if (exp_rsp.status == ST_RANGE) n_range++;
            if (list_len > peak_len) peak_len = list_len;
         end
      end
   end

   task automatic queue_req(input logic [ACTION_W-1:0] act, input value_type val,
                            input logic [POS_W-1:0] pos);
      pending_reqs.push_back('{act, val, pos});
      queued_count++;
   endtask

   // Sender pause: every transfer taken and every response back
   task automatic wait_drain();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_rsps.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Called at a falling edge with the block idle
   task automatic write_capacity(input logic [COUNT_W-1:0] cap);
      csr_capacity <= cap;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      cap_limit = cap;
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mix of extremes, small values for duplicates, and full-range values
   function automatic value_type rand_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      if (sel < 7) return $urandom_range(0, 31);
      if (sel == 7) return '0;
      if (sel == 8) return '1;
      return {8'hFF, 24'($urandom)};
   endfunction

   task automatic run_random_phase(input int n, input int ins_pct, input int ers_pct);
      int r;
      logic [POS_W-1:0] pos;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         pos = POS_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 15));
         if (r < 5) queue_req(ACT_UNUSED, $urandom, POS_W'($urandom));
         else if (r < 5 + ins_pct) queue_req(ACT_INSERT, rand_value(), POS_W'($urandom));
         else if (r < 5 + ins_pct + ers_pct) queue_req(ACT_ERASE, $urandom, pos);
         else queue_req(ACT_READ, $urandom, pos);
      end
   endtask

   // Stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, unused action, extremes, equal values
      queue_req(ACT_READ, '0, 6'd0);
      queue_req(ACT_ERASE, '0, 6'd0);
      queue_req(ACT_UNUSED, '1, 6'd63);
      queue_req(ACT_INSERT, '1, 6'd0);
      queue_req(ACT_INSERT, '0, 6'd63);
      queue_req(ACT_INSERT, 32'd5, 6'd0);
      queue_req(ACT_INSERT, 32'd5, 6'd0);
      queue_req(ACT_INSERT, 32'd7, 6'd0);
      queue_req(ACT_INSERT, 32'd5, 6'd0);
      for (int k = 0; k < 6; k++) queue_req(ACT_READ, '0, POS_W'(k));
      queue_req(ACT_READ, '1, 6'd63);
      queue_req(ACT_ERASE, '1, 6'd1);
      queue_req(ACT_ERASE, '0, 6'd63);
      queue_req(ACT_ERASE, '0, 6'd4);
      queue_req(ACT_READ, '0, 6'd4);
      queue_req(ACT_UNUSED, '0, 6'd0);
      wait_drain();

      // zero capacity, then capacity below the stored count
      write_capacity(7'd0);
      queue_req(ACT_INSERT, 32'd9, 6'd0);
      queue_req(ACT_READ, '0, 6'd0);
      queue_req(ACT_ERASE, '0, 6'd0);
      wait_drain();
      write_capacity(7'd3);
      queue_req(ACT_INSERT, 32'd1, 6'd0);
      queue_req(ACT_INSERT, '1, 6'd0);
      queue_req(ACT_READ, '0, 6'd2);
      wait_drain();

      // capacity above depth saturates: fill to the top, then overflow
      write_capacity(7'd127);
      for (int k = 0; k < DEPTH; k++) queue_req(ACT_INSERT, rand_value(), POS_W'($urandom));
      queue_req(ACT_READ, '0, 6'd63);
      queue_req(ACT_ERASE, '0, 6'd63);
      queue_req(ACT_ERASE, '0, 6'd0);
      queue_req(ACT_READ, '0, 6'd61);
      wait_drain();

      // random phases over a spread of capacities
      run_random_phase(100, 60, 10);
      wait_drain();
      write_capacity(7'd20);
      run_random_phase(100, 40, 25);
      wait_drain();
      write_capacity(7'($urandom_range(0, 127)));
      run_random_phase(100, 45, 30);
      hold_grant++;
      wait_drain();
      write_capacity(7'd1);
      run_random_phase(100, 40, 20);
      wait_drain();
      write_capacity(7'd64);
      run_random_phase(100, 70, 5);
      wait_drain();
      write_capacity(7'd10);
      run_random_phase(100, 30, 20);
      wait_drain();
      write_capacity(7'($urandom_range(0, 127)));
      run_random_phase(100, 40, 30);
      wait_drain();
      write_capacity(7'd127);
      no_idle = 1'b1;
      run_random_phase(100, 50, 20);
      wait_drain();

      repeat (10) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
      $display("Run: %0d transfers (insert %0d, erase %0d, read %0d, unused %0d)",
               accepted_count, n_act[ACT_INSERT], n_act[ACT_ERASE], n_act[ACT_READ],
               n_act[ACT_UNUSED]);
      $display("Run: %0d full, %0d out of range, %0d capacity writes, peak count %0d",
               n_full, n_range, cap_writes, peak_len);
      if (mismatch_count == 0) begin
         $display("tb_sorted_insertion_list_top passed");
      end else begin
         $display("tb_sorted_insertion_list_top failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("tb_sorted_insertion_list_top failed");
      $finish;
   end

endmodule

[sorted_insertion_list_top.f]
rtl/sil_pkg.sv
rtl/sil_cell.sv
rtl/sil_rdsel.sv
rtl/sorted_insertion_list_top.sv
tb/tb_sorted_insertion_list_top.sv
